### hdl/led_fx_pkg.sv
// Shared types and constants for the LED effect generator.
package led_fx_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned PULSE_W = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_FIXED = 2'd0,
    MODE_PULSE = 2'd1,
    MODE_WHEEL = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EFFECT_MODE = 3'd0,
    CFG_RED_LEVEL   = 3'd1,
    CFG_GREEN_LEVEL = 3'd2,
    CFG_BLUE_LEVEL  = 3'd3,
    CFG_SHOW_ENABLE = 3'd4,
    CFG_INTERVAL_MS = 3'd5,
    CFG_BRIGHTNESS  = 3'd6
  } cfg_idx_t;

  localparam logic signed [PULSE_W-1:0] PULSE_STEP      = 10'sd8;
  localparam logic signed [PULSE_W-1:0] PULSE_LOW_MARK  = 10'sd32;
  localparam logic signed [PULSE_W-1:0] PULSE_HIGH_MARK = 10'sd8;
  localparam logic signed [PULSE_W-1:0] PULSE_CLIP_MAX  = 10'sd255;

  localparam logic [LEVEL_W-1:0] WHEEL_THIRD      = 8'h55;
  localparam logic [LEVEL_W-1:0] WHEEL_TWO_THIRDS = 8'hAA;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 8'hFF;

  localparam logic [LEVEL_W-1:0] RESET_BRIGHTNESS = 8'hFF;

  // Saturate a signed pulse level to 0..255
  function automatic logic [LEVEL_W-1:0] clip_level(input logic signed [PULSE_W-1:0] v);
    logic [LEVEL_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > PULSE_CLIP_MAX) begin
      res = LEVEL_MAX;
    end else begin
      res = v[LEVEL_W-1:0];
    end
    return res;
  endfunction

  // Three times a wheel offset; offsets never exceed 85 so the result fits 8 bits
  function automatic logic [LEVEL_W-1:0] times3(input logic [LEVEL_W-1:0] q);
    logic [LEVEL_W:0] prod;
    prod = {q, 1'b0} + {1'b0, q};
    return prod[LEVEL_W-1:0];
  endfunction

endpackage

### hdl/led_effect_generator.sv
// Top level of the single-LED effect generator (fixed, pulse, color wheel).
//
// Usage:
//   Input channel (in_valid/in_stall): one transaction per tick, carrying
//   in_func (0 tick, 1 apply settings then tick) and in_now_ms.
//   Result channel (out_valid/out_stall): at most one frame per input
//   transaction; ticks inside the update interval or with nothing pending
//   produce no frame.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
//   only while no transaction is in flight.
// Path: a frame reaches out_valid through the input register, then the
//   result register (one input register, one result register).
// Throughput: one transaction per cycle while out_stall holds no frame; the
//   whole update is one pass of logic from the input to the result register.
// Stall: while the result register holds a stalled frame, a transaction
//   waiting in the input register holds and in_stall is raised; a frame
//   leaving the result register frees both stages in the same cycle.
// Reset: synchronous, active low; registers return to their defaults
//   (show on, brightness 255, a change and pulse reload pending).
module led_effect_generator
  import led_fx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [TIME_W-1:0]     in_now_ms,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_W-1:0]    out_red_out,
  output logic [LEVEL_W-1:0]    out_green_out,
  output logic [LEVEL_W-1:0]    out_blue_out,
  output logic [LEVEL_W-1:0]    out_brightness_out,
  output logic                  out_blank_frame,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [1:0]          effect_mode_r;
  logic [LEVEL_W-1:0]  red_level_r, green_level_r, blue_level_r;
  logic                show_enable_r;
  logic [TIME_W-1:0]   interval_ms_r;
  logic [LEVEL_W-1:0]  brightness_r;

  // input register
  logic                in_valid_r;
  logic                func_r;
  logic [TIME_W-1:0]   now_r;

  // effect state
  logic                      pulse_dir_r, pulse_dir_nxt;
  logic [LEVEL_W-1:0]        wheel_pos_r, wheel_pos_nxt;
  logic [TIME_W-1:0]         last_update_r, last_update_nxt;
  logic signed [PULSE_W-1:0] pulse_red_r, pulse_green_r, pulse_blue_r;
  logic signed [PULSE_W-1:0] pulse_red_nxt, pulse_green_nxt, pulse_blue_nxt;
  logic                      pending_r, pending_nxt;
  logic                      reload_r, reload_nxt;
  logic [1:0]                amode_r, amode_nxt;
  logic [3*LEVEL_W-1:0]      acolor_r, acolor_nxt;
  logic                      ashow_r, ashow_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]  red_r, green_r, blue_r, bright_r;
  logic                blank_r;

  logic                adv;
  logic                emit;
  logic [LEVEL_W-1:0]  fr_red, fr_green, fr_blue;
  logic                fr_blank;

  assign cfg_ready = 1'b1;
  assign adv       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = !rst_n || (in_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_mode_r <= MODE_FIXED;
      red_level_r   <= '0;
      green_level_r <= '0;
      blue_level_r  <= '0;
      show_enable_r <= 1'b1;
      interval_ms_r <= '0;
      brightness_r  <= RESET_BRIGHTNESS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EFFECT_MODE: effect_mode_r <= cfg_data[1:0];
        CFG_RED_LEVEL:   red_level_r   <= cfg_data[LEVEL_W-1:0];
        CFG_GREEN_LEVEL: green_level_r <= cfg_data[LEVEL_W-1:0];
        CFG_BLUE_LEVEL:  blue_level_r  <= cfg_data[LEVEL_W-1:0];
        CFG_SHOW_ENABLE: show_enable_r <= cfg_data[0];
        CFG_INTERVAL_MS: interval_ms_r <= cfg_data[TIME_W-1:0];
        CFG_BRIGHTNESS:  brightness_r  <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r <= in_func;
      now_r  <= in_now_ms;
    end
  end

  // update pass
  always_comb begin
    logic                      raise;
    logic [3*LEVEL_W-1:0]      col;
    logic                      tick_ok;
    logic signed [PULSE_W-1:0] br, bg, bb;
    logic signed [PULSE_W-1:0] pr, pg, pb;
    logic [LEVEL_W-1:0]        p, q;
    logic [TIME_W-1:0]         elapsed;

    pulse_dir_nxt   = pulse_dir_r;
    wheel_pos_nxt   = wheel_pos_r;
    last_update_nxt = last_update_r;
    pulse_red_nxt   = pulse_red_r;
    pulse_green_nxt = pulse_green_r;
    pulse_blue_nxt  = pulse_blue_r;
    pending_nxt     = pending_r;
    reload_nxt      = reload_r;
    amode_nxt       = amode_r;
    acolor_nxt      = acolor_r;
    ashow_nxt       = ashow_r;
    emit     = 1'b0;
    fr_red   = '0;
    fr_green = '0;
    fr_blue  = '0;
    fr_blank = 1'b0;
    br = '0; bg = '0; bb = '0;
    pr = '0; pg = '0; pb = '0;
    p = '0; q = '0;

    col     = {red_level_r, green_level_r, blue_level_r};
    elapsed = now_r - last_update_r;
    raise   = 1'b0;

    if (func_r) begin
      raise = (effect_mode_r != amode_r) || (show_enable_r != ashow_r) ||
              ((effect_mode_r != MODE_WHEEL) && (col != acolor_r));
      if (effect_mode_r != MODE_WHEEL) begin
        acolor_nxt = col;
      end
      amode_nxt = effect_mode_r;
      ashow_nxt = show_enable_r;
      if (raise) begin
        pending_nxt = 1'b1;
        reload_nxt  = 1'b1;
      end
    end

    // show going off: one black frame in place of the tick
    if (func_r && ashow_r && !show_enable_r) begin
      emit     = 1'b1;
      fr_blank = 1'b1;
      tick_ok  = 1'b0;
    end else begin
      tick_ok = ashow_nxt && (elapsed >= interval_ms_r);
    end

    if (tick_ok) begin
      last_update_nxt = now_r;
      if (amode_nxt == MODE_PULSE) begin
        if (reload_nxt) begin
          br = signed'({2'b00, acolor_nxt[3*LEVEL_W-1:2*LEVEL_W]});
          bg = signed'({2'b00, acolor_nxt[2*LEVEL_W-1:LEVEL_W]});
          bb = signed'({2'b00, acolor_nxt[LEVEL_W-1:0]});
        end else begin
          br = pulse_red_r;
          bg = pulse_green_r;
          bb = pulse_blue_r;
        end
        if (!pulse_dir_r) begin
          pr = br - PULSE_STEP;
          pg = bg - PULSE_STEP;
          pb = bb - PULSE_STEP;
          if (pr <= PULSE_LOW_MARK && pg <= PULSE_LOW_MARK && pb <= PULSE_LOW_MARK) begin
            pulse_dir_nxt = 1'b1;
          end
        end else begin
          pr = br + PULSE_STEP;
          pg = bg + PULSE_STEP;
          pb = bb + PULSE_STEP;
          if (pr >= PULSE_HIGH_MARK && pg >= PULSE_HIGH_MARK && pb >= PULSE_HIGH_MARK) begin
            pulse_dir_nxt = 1'b0;
          end
        end
        pulse_red_nxt   = pr;
        pulse_green_nxt = pg;
        pulse_blue_nxt  = pb;
        fr_red   = clip_level(pr);
        fr_green = clip_level(pg);
        fr_blue  = clip_level(pb);
        emit     = 1'b1;
      end else if (amode_nxt == MODE_WHEEL) begin
        p = LEVEL_MAX - wheel_pos_r;
        if (p < WHEEL_THIRD) begin
          q        = p;
          fr_red   = times3(q);
          fr_green = LEVEL_MAX - times3(q);
          fr_blue  = '0;
        end else if (p < WHEEL_TWO_THIRDS) begin
          q        = p - WHEEL_THIRD;
          fr_red   = LEVEL_MAX - times3(q);
          fr_green = '0;
          fr_blue  = times3(q);
        end else begin
          q        = p - WHEEL_TWO_THIRDS;
          fr_red   = '0;
          fr_green = times3(q);
          fr_blue  = LEVEL_MAX - times3(q);
        end
        wheel_pos_nxt = wheel_pos_r + 1'b1;
        emit          = 1'b1;
      end else begin
        // fixed color, also taken for the unused mode code
        fr_red   = acolor_nxt[3*LEVEL_W-1:2*LEVEL_W];
        fr_green = acolor_nxt[2*LEVEL_W-1:LEVEL_W];
        fr_blue  = acolor_nxt[LEVEL_W-1:0];
        emit     = pending_nxt;
      end
      if (emit) begin
        pending_nxt = 1'b0;
        reload_nxt  = 1'b0;
      end
    end
  end

  always_comb begin
    if (adv) begin
      out_valid_nxt = emit;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_dir_r   <= 1'b0;
      wheel_pos_r   <= '0;
      last_update_r <= '0;
      pulse_red_r   <= '0;
      pulse_green_r <= '0;
      pulse_blue_r  <= '0;
      pending_r     <= 1'b1;
      reload_r      <= 1'b1;
      amode_r       <= MODE_FIXED;
      acolor_r      <= '0;
      ashow_r       <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        pulse_dir_r   <= pulse_dir_nxt;
        wheel_pos_r   <= wheel_pos_nxt;
        last_update_r <= last_update_nxt;
        pulse_red_r   <= pulse_red_nxt;
        pulse_green_r <= pulse_green_nxt;
        pulse_blue_r  <= pulse_blue_nxt;
        pending_r     <= pending_nxt;
        reload_r      <= reload_nxt;
        amode_r       <= amode_nxt;
        acolor_r      <= acolor_nxt;
        ashow_r       <= ashow_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      red_r    <= fr_red;
      green_r  <= fr_green;
      blue_r   <= fr_blue;
      bright_r <= brightness_r;
      blank_r  <= fr_blank;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red_out        = red_r;
  assign out_green_out      = green_r;
  assign out_blue_out       = blue_r;
  assign out_brightness_out = bright_r;
  assign out_blank_frame    = blank_r;

endmodule

### hdl/led_fx_checker.sv
// Port-level assertions for the LED effect generator, bound to the top level.
module led_fx_checker
  import led_fx_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [LEVEL_W-1:0]   out_red_out,
  input logic [LEVEL_W-1:0]   out_green_out,
  input logic [LEVEL_W-1:0]   out_blue_out,
  input logic                 out_blank_frame
);

  // no frame is left over after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // the show-off frame is black
  a_blank_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_blank_frame) |->
      (out_red_out == '0 && out_green_out == '0 && out_blue_out == '0))
    else $error("blank frame carries color");

  // a fresh frame comes from a transaction accepted through the input register
  a_frame_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("frame without a matching input transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_red_out) && $stable(out_green_out) &&
       $stable(out_blue_out) && $stable(out_blank_frame)))
    else $error("stalled frame changed");

endmodule

bind led_effect_generator led_fx_checker u_led_fx_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_red_out     (out_red_out),
  .out_green_out   (out_green_out),
  .out_blue_out    (out_blue_out),
  .out_blank_frame (out_blank_frame)
);

### test/led_effect_generator_tb.sv
// Self-checking testbench for the LED effect generator: directed and random ticks.
module led_effect_generator_tb;
  import led_fx_pkg::*;

  localparam logic [1:0] MODE_SPARE   = 2'd3;  // undefined mode, behaves as fixed
  localparam int         ITEM_TARGET  = 1600;
  localparam int         PRINT_CAP    = 40;
  localparam int         SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] bright;
    logic               blank;
  } frame_t;

  // Tracks register and effect state, predicts frames and checks the result channel.
  class frame_scoreboard;
    logic [1:0]              reg_mode;
    logic [LEVEL_W-1:0]      reg_red, reg_green, reg_blue, reg_bright;
    logic                    reg_show;
    logic [TIME_W-1:0]       reg_interval;

    logic                    fading_up;
    logic [LEVEL_W-1:0]      wheel_pos;
    logic [TIME_W-1:0]       last_ms;
    logic signed [PULSE_W-1:0] pulse_r, pulse_g, pulse_b;
    logic                    change_pending, reload_pending;
    logic [1:0]              live_mode;
    logic [3*LEVEL_W-1:0]    live_color;
    logic                    live_show;

    frame_t expected_frames[$];
    int errors, items, applies, frames, blanks;

    function new();
      reg_mode = MODE_FIXED;
      reg_red = '0; reg_green = '0; reg_blue = '0;
      reg_show = 1'b1; reg_interval = '0; reg_bright = RESET_BRIGHTNESS;
      fading_up = 1'b0; wheel_pos = '0; last_ms = '0;
      pulse_r = '0; pulse_g = '0; pulse_b = '0;
      change_pending = 1'b1; reload_pending = 1'b1;
      live_mode = MODE_FIXED; live_color = '0; live_show = 1'b1;
      errors = 0; items = 0; applies = 0; frames = 0; blanks = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_EFFECT_MODE: reg_mode = d[1:0];
        CFG_RED_LEVEL:   reg_red = d[LEVEL_W-1:0];
        CFG_GREEN_LEVEL: reg_green = d[LEVEL_W-1:0];
        CFG_BLUE_LEVEL:  reg_blue = d[LEVEL_W-1:0];
        CFG_SHOW_ENABLE: reg_show = d[0];
        CFG_INTERVAL_MS: reg_interval = d;
        CFG_BRIGHTNESS:  reg_bright = d[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [LEVEL_W-1:0] saturate(logic signed [PULSE_W-1:0] v);
      if (v < 0) return '0;
      if (v > 255) return LEVEL_MAX;
      return v[LEVEL_W-1:0];
    endfunction

    function void push_frame(logic [LEVEL_W-1:0] r, g, b, logic blank);
      frame_t f;
      f.red = r; f.green = g; f.blue = b; f.bright = reg_bright; f.blank = blank;
      expected_frames.push_back(f);
    endfunction

    function void step_pulse();
      if (!fading_up) begin
        pulse_r -= PULSE_STEP; pulse_g -= PULSE_STEP; pulse_b -= PULSE_STEP;
        if (pulse_r <= PULSE_LOW_MARK && pulse_g <= PULSE_LOW_MARK &&
            pulse_b <= PULSE_LOW_MARK)
          fading_up = 1'b1;
      end else begin
        pulse_r += PULSE_STEP; pulse_g += PULSE_STEP; pulse_b += PULSE_STEP;
        if (pulse_r >= PULSE_HIGH_MARK && pulse_g >= PULSE_HIGH_MARK &&
            pulse_b >= PULSE_HIGH_MARK)
          fading_up = 1'b0;
      end
    endfunction

    function void predict_tick(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0]  elapsed;
      logic [LEVEL_W-1:0] r, g, b, p, q;
      if (!live_show) return;
      elapsed = now - last_ms;
      if (elapsed < reg_interval) return;
      last_ms = now;
      case (live_mode)
        MODE_PULSE: begin
          if (reload_pending) begin
            pulse_r = $signed({2'b00, live_color[23:16]});
            pulse_g = $signed({2'b00, live_color[15:8]});
            pulse_b = $signed({2'b00, live_color[7:0]});
          end
          step_pulse();
          r = saturate(pulse_r); g = saturate(pulse_g); b = saturate(pulse_b);
          change_pending = 1'b1;
        end
        MODE_WHEEL: begin
          p = LEVEL_MAX - wheel_pos;
          if (p < WHEEL_THIRD) begin
            r = LEVEL_W'(3 * p); g = LEVEL_W'(LEVEL_MAX - 3 * p); b = '0;
          end else if (p < WHEEL_TWO_THIRDS) begin
            q = p - WHEEL_THIRD;
            r = LEVEL_W'(LEVEL_MAX - 3 * q); g = '0; b = LEVEL_W'(3 * q);
          end else begin
            q = p - WHEEL_TWO_THIRDS;
            r = '0; g = LEVEL_W'(3 * q); b = LEVEL_W'(LEVEL_MAX - 3 * q);
          end
          wheel_pos = wheel_pos + 1'b1;
          change_pending = 1'b1;
        end
        default: begin
          r = live_color[23:16]; g = live_color[15:8]; b = live_color[7:0];
        end
      endcase
      if (!change_pending) return;
      push_frame(r, g, b, 1'b0);
      change_pending = 1'b0;
      reload_pending = 1'b0;
    endfunction

    // Called for every accepted input transaction.
    function void note_item(logic func, logic [TIME_W-1:0] now);
      logic                 raise, was_shown;
      logic [3*LEVEL_W-1:0] col;
      items++;
      if (func) begin
        applies++;
        col = {reg_red, reg_green, reg_blue};
        was_shown = live_show;
        raise = (reg_mode != live_mode) || (reg_show != live_show);
        if (reg_mode != MODE_WHEEL) begin
          if (col != live_color) raise = 1'b1;
          live_color = col;
        end
        live_mode = reg_mode;
        live_show = reg_show;
        if (raise) begin
          change_pending = 1'b1;
          reload_pending = 1'b1;
        end
        // show going off sends black and skips the tick; pending flags stay up
        if (was_shown && !live_show) begin
          push_frame('0, '0, '0, 1'b1);
          return;
        end
      end
      predict_tick(now);
    endfunction

    function int outstanding();
      return expected_frames.size();
    endfunction

    task report(string what);
      if (errors < PRINT_CAP) $display("ERROR @%0t: %s", $time, what);
      errors++;
    endtask

    task check_frame(frame_t got);
      frame_t exp;
      if (expected_frames.size() == 0) begin
        report($sformatf("unexpected frame r=%0d g=%0d b=%0d", got.red, got.green, got.blue));
        return;
      end
      exp = expected_frames.pop_front();
      frames++;
      if (exp.blank) blanks++;
      if (got.red !== exp.red)
        report($sformatf("frame %0d red %0d, want %0d", frames, got.red, exp.red));
      if (got.green !== exp.green)
        report($sformatf("frame %0d green %0d, want %0d", frames, got.green, exp.green));
      if (got.blue !== exp.blue)
        report($sformatf("frame %0d blue %0d, want %0d", frames, got.blue, exp.blue));
      if (got.bright !== exp.bright)
        report($sformatf("frame %0d brightness %0d, want %0d", frames, got.bright, exp.bright));
      if (got.blank !== exp.blank)
        report($sformatf("frame %0d blank %0b, want %0b", frames, got.blank, exp.blank));
    endtask

    task final_check();
      if (expected_frames.size() != 0)
        report($sformatf("%0d expected frames never arrived", expected_frames.size()));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid, in_stall, in_func;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid, out_stall;
  logic [LEVEL_W-1:0]    out_red_out, out_green_out, out_blue_out, out_brightness_out;
  logic                  out_blank_frame;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic                  steady;      // no idling on either side while set
  logic [TIME_W-1:0]     clock_ms;
  int                    phases;
  frame_scoreboard       sb;

  led_effect_generator i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_func, .in_now_ms,
    .out_valid, .out_stall, .out_red_out, .out_green_out, .out_blue_out,
    .out_brightness_out, .out_blank_frame,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 32);
  end

  always @(posedge clk) begin : result_monitor
    frame_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.red = out_red_out; seen.green = out_green_out; seen.blue = out_blue_out;
      seen.bright = out_brightness_out; seen.blank = out_blank_frame;
      sb.check_frame(seen);
    end
  end

  // All tasks start and end at a falling edge.
  task automatic send_item(input logic func, input logic [TIME_W-1:0] now);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_func = func;
    in_now_ms = now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(func, now);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_settings(input logic [1:0] mode, input logic [LEVEL_W-1:0] r, g, b,
                               input logic show, input logic [TIME_W-1:0] interval,
                               input logic [LEVEL_W-1:0] bright);
    settle();
    write_reg(CFG_EFFECT_MODE, {30'd0, mode});
    write_reg(CFG_RED_LEVEL, {24'd0, r});
    write_reg(CFG_GREEN_LEVEL, {24'd0, g});
    write_reg(CFG_BLUE_LEVEL, {24'd0, b});
    write_reg(CFG_SHOW_ENABLE, {31'd0, show});
    write_reg(CFG_INTERVAL_MS, interval);
    write_reg(CFG_BRIGHTNESS, {24'd0, bright});
    phases++;
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return '0;
    if (sel < 4) return LEVEL_MAX;
    return LEVEL_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [TIME_W-1:0] pick_interval();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return '0;
    if (sel < 8) return $urandom_range(1, 4);
    if (sel == 8) return '1;
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_mode();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return MODE_FIXED;
    if (sel < 6) return MODE_PULSE;
    if (sel < 9) return MODE_WHEEL;
    return MODE_SPARE;
  endfunction

  // Next tick time: mostly near the interval boundary, sometimes a random jump.
  function automatic logic [TIME_W-1:0] next_time(logic [TIME_W-1:0] interval);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) return $urandom();
    if (interval <= 16) return clock_ms + $urandom_range(0, interval + 2);
    if (sel < 45) return clock_ms + interval;
    if (sel < 70) return clock_ms + interval - 1'b1;
    return clock_ms + $urandom_range(0, 1000);
  endfunction

  initial begin
    #800000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int                 count;
    logic [TIME_W-1:0]  interval;
    sb = new();
    phases = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_now_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_EFFECT_MODE;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Defaults: fixed black with a change pending, then nothing pending.
    send_item(1'b0, 32'd0);
    send_item(1'b0, 32'd1);
    // Pulse from a dim color: channels go negative, direction turns up, then down.
    load_settings(MODE_PULSE, 8'd40, 8'd0, 8'd0, 1'b1, 32'd0, 8'd0);
    send_item(1'b1, 32'd2);
    send_item(1'b0, 32'd3);
    send_item(1'b0, 32'd4);
    // Reload while falling: red steps down from 255.
    load_settings(MODE_PULSE, LEVEL_MAX, 8'd0, 8'd0, 1'b1, 32'd0, LEVEL_MAX);
    send_item(1'b1, 32'd5);
    send_item(1'b0, 32'd6);
    // Wheel with a short interval: ticks inside the interval are dropped.
    load_settings(MODE_WHEEL, 8'd7, 8'd8, 8'd9, 1'b1, 32'd3, 8'd128);
    send_item(1'b1, 32'd7);
    send_item(1'b0, 32'd9);
    send_item(1'b0, 32'd10);
    send_item(1'b0, 32'd12);
    // Undefined mode acts as fixed.
    load_settings(MODE_SPARE, 8'd1, 8'd2, 8'd3, 1'b1, 32'd3, 8'd77);
    send_item(1'b1, 32'd20);
    send_item(1'b0, 32'd30);
    // Show off: one black frame, then silence.
    load_settings(MODE_SPARE, 8'd1, 8'd2, 8'd3, 1'b0, 32'd3, 8'd77);
    send_item(1'b1, 32'd31);
    send_item(1'b0, 32'd40);
    send_item(1'b1, 32'd41);
    // Largest interval: only an elapsed time of all ones passes.
    load_settings(MODE_FIXED, 8'hAA, 8'h55, LEVEL_MAX, 1'b1, '1, 8'd200);
    send_item(1'b1, 32'd50);
    send_item(1'b0, 32'd29);
    send_item(1'b0, 32'hFFFF_FFF0);
    load_settings(MODE_FIXED, 8'hAA, 8'h55, LEVEL_MAX, 1'b1, 32'd0, 8'd200);
    send_item(1'b1, 32'hFFFF_FFFF);
    send_item(1'b0, 32'd0);

    clock_ms = '0;
    while (sb.items < ITEM_TARGET) begin
      interval = pick_interval();
      load_settings(pick_mode(), pick_level(), pick_level(), pick_level(),
                    $urandom_range(0, 99) >= 15, interval, pick_level());
      steady = (phases >= 14 && phases < 20);
      if ($urandom_range(0, 9) == 0) clock_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      count = $urandom_range(20, 60);
      for (int k = 0; k < count; k++) begin
        clock_ms = next_time(interval);
        if (k == 0) send_item($urandom_range(0, 4) != 0, clock_ms);
        else send_item($urandom_range(0, 19) == 0, clock_ms);
      end
    end
    steady = 1'b0;

    settle();
    sb.final_check();
    $display("Ran %0d transactions (%0d applies) across %0d register settings.",
             sb.items, sb.applies, phases);
    $display("Checked %0d frames, %0d of them blank frames from show off.",
             sb.frames, sb.blanks);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
